### rtl/hvd_pkg.sv
// Shared types, constants and table functions for the haversine distance block.
// Depends on nothing; every other file refers to it by scoped names.
package hvd_pkg;

	// Word field widths
	localparam int LAT_W    = 28;
	localparam int LON_W    = 29;
	localparam int RADIUS_W = 24;
	localparam int DIST_W   = 26;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

	// Angle format and CORDIC depth
	localparam int CORDIC_ITERATIONS   = 24;
	localparam int ANGLE_FRACTION_BITS = 20;
	localparam int TURN_W     = 32;
	localparam int LAT_SHIFT  = 32 - ANGLE_FRACTION_BITS;
	localparam int HALF_SHIFT = 31 - ANGLE_FRACTION_BITS;
	localparam int DEG_TURN   = 360;
	localparam int DEG_HALF   = 180;

	// Four rotations per word
	localparam int LANES         = 4;
	localparam int LANE_LAT_A    = 0;
	localparam int LANE_LAT_B    = 1;
	localparam int LANE_HALF_LAT = 2;
	localparam int LANE_HALF_LON = 3;

	// Degree to turn conversion: split |v| = 45*q + r, then q*2^(k-3) + table[r]
	localparam int MAG_W       = 30;
	localparam int RECIP_W     = 31;
	localparam int RECIP_SHIFT = 36;
	localparam logic [RECIP_W-1:0] RECIP45 = 31'd1527099483;
	localparam int DIV_BASE    = 45;
	localparam int REM_IDX_W   = $clog2(DIV_BASE);
	localparam int QUO_W       = MAG_W + RECIP_W - RECIP_SHIFT;
	localparam int TURN_PRE    = 3;

	localparam logic signed [TURN_W-1:0] QUARTER = 32'sd1073741824;

	// Rotation datapath
	localparam int ROT_W  = 32;
	localparam int ROTZ_W = TURN_W + 1;
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 32'sd652032875;

	// Products and the sum a in Q60
	localparam int PROD_W = 64;
	localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd536870912;
	localparam int Q_SHIFT = 30;
	localparam int A_W = 61;
	localparam logic [A_W-1:0] ONE60 = 61'h1000000000000000;

	// Roots and vectoring
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_W     = 64;
	localparam int VEC_W      = 49;
	localparam int VEC_SHIFT  = 16;
	localparam int ROOT_W     = 31;
	localparam int ANG_W      = 31;
	localparam logic [ANG_W-1:0] ANG_ONE = 31'h40000000;

	// Scaling: pi in Q32 split as 3*2^32 + PI_LO
	localparam int PI_LO_W = 30;
	localparam logic [PI_LO_W-1:0] PI_LO = 30'd608135817;
	localparam int PI_HI_W = ANG_W + 2;
	localparam logic [1:0] PI_HI = 2'd3;
	localparam int CQ_W       = 34;
	localparam int CQ_SPLIT   = 17;
	localparam int RAD_PROD_W = RADIUS_W + CQ_SPLIT;

	// Queue between front and back
	localparam int MQ_DEPTH = 4;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);

	typedef struct packed {
		logic signed [TURN_W-1:0] z;
		logic                     flip;
	} rot_job_t;

	typedef rot_job_t [LANES-1:0] job_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} mq_view_t;

	// atan(2^-i) as a binary angle, one turn = 2^32
	function automatic logic [TURN_W-1:0] atan_turn(input int i);
		logic [TURN_W-1:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// round(r * 2^k / 360), r below 45; evaluated on constants only
	function automatic logic [TURN_W-1:0] rem_turn(input int r, input int k);
		longint v;
		v = (longint'(r) << k) + longint'(DEG_HALF);
		return TURN_W'(v / DEG_TURN);
	endfunction

endpackage

### rtl/hvd_front.sv
// Front end: takes input words, turns degrees into binary angles and folds them
// into the CORDIC range, then holds them in a short queue. Uses hvd_pkg.
module hvd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [hvd_pkg::LAT_W-1:0]  lat_a,
	input  logic signed [hvd_pkg::LON_W-1:0]  lon_a,
	input  logic signed [hvd_pkg::LAT_W-1:0]  lat_b,
	input  logic signed [hvd_pkg::LON_W-1:0]  lon_b,
	input  logic                              q_pop,
	output hvd_pkg::mq_view_t                 q_view
);

	localparam int Lanes = hvd_pkg::LANES;
	localparam int WideW = hvd_pkg::MAG_W + 1;
	localparam int ProdW = hvd_pkg::MAG_W + hvd_pkg::RECIP_W;

	logic en_f;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [hvd_pkg::LAT_W-1:0] lat_a_s1, lat_b_s1;
	logic signed [hvd_pkg::LON_W-1:0] lon_a_s1, lon_b_s1;

	logic signed [WideW-1:0]          wide_w [Lanes];
	logic [hvd_pkg::MAG_W-1:0]        mag_w  [Lanes];
	logic [hvd_pkg::MAG_W-1:0]        mag_s2 [Lanes];
	logic                             neg_s2 [Lanes];
	logic [ProdW-1:0]                 prod_w [Lanes];
	logic [hvd_pkg::QUO_W-1:0]        quo_s3 [Lanes];
	logic [hvd_pkg::MAG_W-1:0]        mag_s3 [Lanes];
	logic                             neg_s3 [Lanes];
	logic [hvd_pkg::MAG_W-1:0]        rem_raw [Lanes];
	logic [hvd_pkg::QUO_W-1:0]        quo_fix [Lanes];
	logic [hvd_pkg::REM_IDX_W-1:0]    rem_idx [Lanes];
	logic [hvd_pkg::TURN_W-1:0]       mag_turn [Lanes];
	logic [hvd_pkg::TURN_W-1:0]       turn_w [Lanes];
	logic [hvd_pkg::TURN_W-1:0]       turn_s4 [Lanes];
	logic [hvd_pkg::TURN_W-1:0]       tab_full [hvd_pkg::DIV_BASE];
	logic [hvd_pkg::TURN_W-1:0]       tab_half [hvd_pkg::DIV_BASE];
	hvd_pkg::job_t                    job_w;

	hvd_pkg::job_t                    mq_q [hvd_pkg::MQ_DEPTH];
	logic [hvd_pkg::MQ_PTR_W-1:0]     wr_q, rd_q;
	logic [hvd_pkg::MQ_PTR_W:0]       cnt_q;
	logic                             mq_push;

	// Advance the whole front unless the queue is full and nothing leaves it
	assign en_f    = !(cnt_q == (hvd_pkg::MQ_PTR_W+1)'(hvd_pkg::MQ_DEPTH) && !q_pop);
	assign full    = !en_f;
	assign mq_push = en_f && v_s4;

	always_comb begin
		for (int i = 0; i < hvd_pkg::DIV_BASE; i++) begin
			tab_full[i] = hvd_pkg::rem_turn(i, hvd_pkg::LAT_SHIFT);
			tab_half[i] = hvd_pkg::rem_turn(i, hvd_pkg::HALF_SHIFT);
		end
	end

	always_comb begin
		wide_w[hvd_pkg::LANE_LAT_A]    = WideW'(lat_a_s1);
		wide_w[hvd_pkg::LANE_LAT_B]    = WideW'(lat_b_s1);
		wide_w[hvd_pkg::LANE_HALF_LAT] = WideW'(lat_b_s1) - WideW'(lat_a_s1);
		wide_w[hvd_pkg::LANE_HALF_LON] = WideW'(lon_b_s1) - WideW'(lon_a_s1);
		for (int l = 0; l < Lanes; l++) begin
			mag_w[l]  = wide_w[l][WideW-1] ? hvd_pkg::MAG_W'(-wide_w[l])
			                               : hvd_pkg::MAG_W'(wide_w[l]);
			prod_w[l] = ProdW'(mag_s2[l]) * ProdW'(hvd_pkg::RECIP45);
		end
	end

	// Correct the quotient estimate by one step, then rebuild the turn
	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			rem_raw[l] = mag_s3[l] - hvd_pkg::MAG_W'(hvd_pkg::MAG_W'(quo_s3[l])
			             * hvd_pkg::MAG_W'(hvd_pkg::DIV_BASE));
			quo_fix[l] = quo_s3[l];
			if (rem_raw[l] >= hvd_pkg::MAG_W'(hvd_pkg::DIV_BASE)) begin
				quo_fix[l] = quo_s3[l] + hvd_pkg::QUO_W'(1);
				rem_raw[l] = rem_raw[l] - hvd_pkg::MAG_W'(hvd_pkg::DIV_BASE);
			end
			rem_idx[l] = hvd_pkg::REM_IDX_W'(rem_raw[l]);
			if (l < hvd_pkg::LANE_HALF_LAT) begin
				mag_turn[l] = (hvd_pkg::TURN_W'(quo_fix[l])
				              << (hvd_pkg::LAT_SHIFT - hvd_pkg::TURN_PRE))
				              + tab_full[rem_idx[l]];
			end else begin
				mag_turn[l] = (hvd_pkg::TURN_W'(quo_fix[l])
				              << (hvd_pkg::HALF_SHIFT - hvd_pkg::TURN_PRE))
				              + tab_half[rem_idx[l]];
			end
			turn_w[l] = neg_s3[l] ? -mag_turn[l] : mag_turn[l];
		end
	end

	// Fold into [-quarter, quarter]; a half turn shift only flips the top bit
	always_comb begin
		for (int l = 0; l < Lanes; l++) begin
			if ($signed(turn_s4[l]) > hvd_pkg::QUARTER ||
			    $signed(turn_s4[l]) < -hvd_pkg::QUARTER) begin
				job_w[l].z    = $signed({~turn_s4[l][hvd_pkg::TURN_W-1],
				                         turn_s4[l][hvd_pkg::TURN_W-2:0]});
				job_w[l].flip = 1'b1;
			end else begin
				job_w[l].z    = $signed(turn_s4[l]);
				job_w[l].flip = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			lat_a_s1 <= lat_a;
			lon_a_s1 <= lon_a;
			lat_b_s1 <= lat_b;
			lon_b_s1 <= lon_b;
			for (int l = 0; l < Lanes; l++) begin
				neg_s2[l]  <= wide_w[l][WideW-1];
				mag_s2[l]  <= mag_w[l];
				quo_s3[l]  <= prod_w[l][ProdW-1:hvd_pkg::RECIP_SHIFT];
				mag_s3[l]  <= mag_s2[l];
				neg_s3[l]  <= neg_s2[l];
				turn_s4[l] <= turn_w[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mq_push) begin
			mq_q[wr_q] <= job_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (mq_push) begin
				wr_q <= wr_q + hvd_pkg::MQ_PTR_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + hvd_pkg::MQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + (hvd_pkg::MQ_PTR_W+1)'(mq_push)
			               - (hvd_pkg::MQ_PTR_W+1)'(q_pop);
		end
	end

	assign q_view.avail = (cnt_q != '0);
	assign q_view.job   = mq_q[rd_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(mq_push && !q_pop) |-> cnt_q < (hvd_pkg::MQ_PTR_W+1)'(hvd_pkg::MQ_DEPTH))
		else $error("front queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0)
		else $error("front queue read while empty");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en_f |=> $stable(v_s4))
		else $error("front stage moved while stalled");

endmodule

### rtl/hvd_back.sv
// Back end: four rotation CORDICs, the haversine products, two pipelined roots,
// a vectoring CORDIC and radius scaling, then a two-entry result queue. Uses hvd_pkg.
module hvd_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [hvd_pkg::RADIUS_W-1:0]       radius,
	input  hvd_pkg::mq_view_t                  q_view,
	output logic                               q_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic [hvd_pkg::DIST_W-1:0]         distance_m
);

	localparam int Ci         = hvd_pkg::CORDIC_ITERATIONS;
	localparam int Sq         = hvd_pkg::SQRT_STEPS;
	localparam int Lanes      = hvd_pkg::LANES;
	localparam int BackStages = 2 * Ci + 45;
	localparam int SumW       = hvd_pkg::PROD_W + 1;
	localparam int CqSumW     = hvd_pkg::PI_HI_W + 32;
	localparam int DistSumW   = hvd_pkg::RAD_PROD_W + hvd_pkg::CQ_SPLIT + 2;
	localparam int OqDepth    = 2;

	typedef struct packed {
		logic signed [hvd_pkg::ROT_W-1:0]  x;
		logic signed [hvd_pkg::ROT_W-1:0]  y;
		logic signed [hvd_pkg::ROTZ_W-1:0] z;
		logic                              flip;
	} rot_t;

	typedef struct packed {
		logic [hvd_pkg::SQRT_W-1:0] v;
		logic [hvd_pkg::SQRT_W-1:0] r;
	} root_t;

	typedef struct packed {
		logic signed [hvd_pkg::VEC_W-1:0]  x;
		logic signed [hvd_pkg::VEC_W-1:0]  y;
		logic signed [hvd_pkg::ROTZ_W-1:0] z;
	} vec_t;

	function automatic rot_t rot_step(input rot_t s, input int i);
		rot_t o;
		logic signed [hvd_pkg::ROTZ_W-1:0] a;
		a = $signed({1'b0, hvd_pkg::atan_turn(i)});
		o = s;
		if (!s.z[hvd_pkg::ROTZ_W-1]) begin
			o.x = s.x - (s.y >>> i);
			o.y = s.y + (s.x >>> i);
			o.z = s.z - a;
		end else begin
			o.x = s.x + (s.y >>> i);
			o.y = s.y - (s.x >>> i);
			o.z = s.z + a;
		end
		return o;
	endfunction

	function automatic root_t root_step(input root_t s, input int k);
		root_t o;
		logic [hvd_pkg::SQRT_W-1:0] b;
		logic [hvd_pkg::SQRT_W-1:0] t;
		b = hvd_pkg::SQRT_W'(1) << (2 * (Sq - 1 - k));
		t = s.r + b;
		if (s.v >= t) begin
			o.v = s.v - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	function automatic vec_t vec_step(input vec_t s, input int i);
		vec_t o;
		logic signed [hvd_pkg::ROTZ_W-1:0] a;
		a = $signed({1'b0, hvd_pkg::atan_turn(i)});
		if (!s.y[hvd_pkg::VEC_W-1]) begin
			o.x = s.x + (s.y >>> i);
			o.y = s.y - (s.x >>> i);
			o.z = s.z + a;
		end else begin
			o.x = s.x - (s.y >>> i);
			o.y = s.y + (s.x >>> i);
			o.z = s.z - a;
		end
		return o;
	endfunction

	logic                         en_b;
	logic                         pop_fire;
	logic [BackStages-1:0]        vld_q;

	rot_t  rot_s  [Ci+1][Lanes];
	root_t root_s [Sq][2];
	root_t root_seed [2];
	vec_t  vec_s  [Ci];
	vec_t  vec_seed;

	logic signed [hvd_pkg::ROT_W-1:0]  ca_s1, cb_s1, slat_s1, slon_s1;
	logic signed [hvd_pkg::PROD_W-1:0] pab_s2, sq_s2, sq_s3, sq_s4, sq_s5, sq_s6;
	logic signed [hvd_pkg::ROT_W-1:0]  slon_s2, slon_s3, slon_s4, slon_s5;
	logic signed [hvd_pkg::ROT_W-1:0]  cab_s3, p_s5;
	logic signed [hvd_pkg::PROD_W-1:0] pq_s4, ps_s6;
	logic signed [SumW-1:0]            a_sum;
	logic [hvd_pkg::A_W-1:0]           a_s7;
	logic [hvd_pkg::ANG_W-1:0]         ang_s8;
	logic [hvd_pkg::ANG_W+hvd_pkg::PI_LO_W-1:0] plo_s9;
	logic [hvd_pkg::PI_HI_W-1:0]       phi_s9;
	logic [CqSumW-1:0]                 cq_sum;
	logic [hvd_pkg::CQ_W-1:0]          cq_s10;
	logic [hvd_pkg::RAD_PROD_W-1:0]    ph_s11, pl_s11;
	logic [DistSumW-1:0]               dist_sum;
	logic [hvd_pkg::DIST_W-1:0]        dist_s12;

	logic [hvd_pkg::DIST_W-1:0]        oq_q [OqDepth];
	logic                              oq_wr_q, oq_rd_q;
	logic [1:0]                        oq_cnt_q;
	logic                              oq_push;

	// Stall every stage together only when the result queue cannot take a word
	assign pop_fire = pop && !empty;
	assign en_b     = !(oq_cnt_q == 2'(OqDepth) && !pop_fire);
	assign q_pop    = en_b && q_view.avail;
	assign oq_push  = en_b && vld_q[BackStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en_b) begin
			vld_q <= {vld_q[BackStages-2:0], q_pop};
		end
	end

	// Load the rotation stage with the gain-scaled unit vector
	always_ff @(posedge clk) begin
		if (en_b) begin
			for (int l = 0; l < Lanes; l++) begin
				rot_s[0][l].x    <= hvd_pkg::CORDIC_GAIN;
				rot_s[0][l].y    <= '0;
				rot_s[0][l].z    <= hvd_pkg::ROTZ_W'(q_view.job[l].z);
				rot_s[0][l].flip <= q_view.job[l].flip;
			end
		end
	end

	for (genvar i = 0; i < Ci; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en_b) begin
				for (int l = 0; l < Lanes; l++) begin
					rot_s[i+1][l] <= rot_step(rot_s[i][l], i);
				end
			end
		end
	end

	always_comb begin
		a_sum = SumW'(sq_s6) + SumW'(ps_s6);
		if (a_sum < 0) begin
			root_seed[0].v = '0;
		end else if (a_sum > SumW'(hvd_pkg::ONE60)) begin
			root_seed[0].v = hvd_pkg::SQRT_W'(hvd_pkg::ONE60);
		end else begin
			root_seed[0].v = hvd_pkg::SQRT_W'(a_sum);
		end
		root_seed[0].r = '0;
		root_seed[1].v = '0;
		root_seed[1].r = '0;
	end

	// Products run one multiply per stage with rounding in between
	always_ff @(posedge clk) begin
		if (en_b) begin
			ca_s1   <= rot_s[Ci][hvd_pkg::LANE_LAT_A].flip ? -rot_s[Ci][hvd_pkg::LANE_LAT_A].x
			                                              : rot_s[Ci][hvd_pkg::LANE_LAT_A].x;
			cb_s1   <= rot_s[Ci][hvd_pkg::LANE_LAT_B].flip ? -rot_s[Ci][hvd_pkg::LANE_LAT_B].x
			                                              : rot_s[Ci][hvd_pkg::LANE_LAT_B].x;
			slat_s1 <= rot_s[Ci][hvd_pkg::LANE_HALF_LAT].flip
			           ? -rot_s[Ci][hvd_pkg::LANE_HALF_LAT].y : rot_s[Ci][hvd_pkg::LANE_HALF_LAT].y;
			slon_s1 <= rot_s[Ci][hvd_pkg::LANE_HALF_LON].flip
			           ? -rot_s[Ci][hvd_pkg::LANE_HALF_LON].y : rot_s[Ci][hvd_pkg::LANE_HALF_LON].y;

			pab_s2  <= hvd_pkg::PROD_W'(ca_s1) * hvd_pkg::PROD_W'(cb_s1);
			sq_s2   <= hvd_pkg::PROD_W'(slat_s1) * hvd_pkg::PROD_W'(slat_s1);
			slon_s2 <= slon_s1;

			cab_s3  <= hvd_pkg::ROT_W'((pab_s2 + hvd_pkg::RND_HALF) >>> hvd_pkg::Q_SHIFT);
			sq_s3   <= sq_s2;
			slon_s3 <= slon_s2;

			pq_s4   <= hvd_pkg::PROD_W'(cab_s3) * hvd_pkg::PROD_W'(slon_s3);
			sq_s4   <= sq_s3;
			slon_s4 <= slon_s3;

			p_s5    <= hvd_pkg::ROT_W'((pq_s4 + hvd_pkg::RND_HALF) >>> hvd_pkg::Q_SHIFT);
			sq_s5   <= sq_s4;
			slon_s5 <= slon_s4;

			ps_s6   <= hvd_pkg::PROD_W'(p_s5) * hvd_pkg::PROD_W'(slon_s5);
			sq_s6   <= sq_s5;

			a_s7    <= hvd_pkg::A_W'(root_seed[0].v);
		end
	end

	// Root step k: index 0 is sqrt(a), index 1 is sqrt(1 - a)
	for (genvar k = 0; k < Sq; k++) begin : g_root
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en_b) begin
					root_s[0][0] <= root_step('{v: hvd_pkg::SQRT_W'(a_s7), r: '0}, 0);
					root_s[0][1] <= root_step('{v: hvd_pkg::SQRT_W'(hvd_pkg::ONE60 - a_s7),
					                            r: '0}, 0);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en_b) begin
					root_s[k][0] <= root_step(root_s[k-1][0], k);
					root_s[k][1] <= root_step(root_s[k-1][1], k);
				end
			end
		end
	end

	always_comb begin
		vec_seed.x = $signed(hvd_pkg::VEC_W'(root_s[Sq-1][1].r[hvd_pkg::ROOT_W-1:0])
		             << hvd_pkg::VEC_SHIFT);
		vec_seed.y = $signed(hvd_pkg::VEC_W'(root_s[Sq-1][0].r[hvd_pkg::ROOT_W-1:0])
		             << hvd_pkg::VEC_SHIFT);
		vec_seed.z = '0;
	end

	for (genvar i = 0; i < Ci; i++) begin : g_vec
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en_b) begin
					vec_s[0] <= vec_step(vec_seed, 0);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en_b) begin
					vec_s[i] <= vec_step(vec_s[i-1], i);
				end
			end
		end
	end

	always_comb begin
		cq_sum   = (CqSumW'(phi_s9) << 32) + CqSumW'(plo_s9)
		           + (CqSumW'(1) << (hvd_pkg::Q_SHIFT - 1));
		dist_sum = (DistSumW'(ph_s11) << hvd_pkg::CQ_SPLIT) + DistSumW'(pl_s11)
		           + (DistSumW'(1) << 31);
	end

	// Clamp the half angle, scale by pi, then by the radius
	always_ff @(posedge clk) begin
		if (en_b) begin
			if (vec_s[Ci-1].z[hvd_pkg::ROTZ_W-1]) begin
				ang_s8 <= '0;
			end else if (vec_s[Ci-1].z > $signed(hvd_pkg::ROTZ_W'(hvd_pkg::ANG_ONE))) begin
				ang_s8 <= hvd_pkg::ANG_ONE;
			end else begin
				ang_s8 <= hvd_pkg::ANG_W'(vec_s[Ci-1].z);
			end
			plo_s9   <= (hvd_pkg::ANG_W+hvd_pkg::PI_LO_W)'(ang_s8)
			            * (hvd_pkg::ANG_W+hvd_pkg::PI_LO_W)'(hvd_pkg::PI_LO);
			phi_s9   <= hvd_pkg::PI_HI_W'(ang_s8) * hvd_pkg::PI_HI_W'(hvd_pkg::PI_HI);
			cq_s10   <= cq_sum[hvd_pkg::CQ_W+hvd_pkg::Q_SHIFT-1:hvd_pkg::Q_SHIFT];
			ph_s11   <= hvd_pkg::RAD_PROD_W'(radius)
			            * hvd_pkg::RAD_PROD_W'(cq_s10[hvd_pkg::CQ_W-1:hvd_pkg::CQ_SPLIT]);
			pl_s11   <= hvd_pkg::RAD_PROD_W'(radius)
			            * hvd_pkg::RAD_PROD_W'(cq_s10[hvd_pkg::CQ_SPLIT-1:0]);
			dist_s12 <= dist_sum[hvd_pkg::DIST_W+31:32];
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= dist_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (pop_fire) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(pop_fire);
		end
	end

	assign empty      = (oq_cnt_q == '0);
	assign distance_m = oq_q[oq_rd_q];

	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && !pop_fire) |-> oq_cnt_q != 2'(OqDepth))
		else $error("result queue written while full");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en_b |-> oq_cnt_q == 2'(OqDepth))
		else $error("back end stalled with room in result queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en_b |=> $stable(vld_q))
		else $error("back end advanced while stalled");

endmodule

### rtl/haversine_distance_top.sv
// Top level of the haversine great-circle distance block: radius register,
// front end and back end. Uses hvd_pkg, hvd_front and hvd_back.
//
// An accepted push runs through the front stages and queue, then the back
// pipeline and the result queue, to the result ports.
// Throughput: one word per cycle unless a full result queue with pop low stalls
// it; every stage is unrolled, so the CORDIC and root pipelines never set rate.
// Reset: arst_n clears all valid bits, queue pointers and counts at once and
// loads the radius with 6371000 m; no clearing pass, ready on the next edge.
module haversine_distance_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input side, queue style
	input  logic                              push,
	output logic                              full,
	input  logic signed [hvd_pkg::LAT_W-1:0]  lat_a,
	input  logic signed [hvd_pkg::LON_W-1:0]  lon_a,
	input  logic signed [hvd_pkg::LAT_W-1:0]  lat_b,
	input  logic signed [hvd_pkg::LON_W-1:0]  lon_b,
	// Result side, queue style
	output logic                              empty,
	input  logic                              pop,
	output logic [hvd_pkg::DIST_W-1:0]        distance_m,
	// Radius register write port
	input  logic                              cfg_we,
	input  logic [hvd_pkg::RADIUS_W-1:0]      cfg_wdata
);

	logic [hvd_pkg::RADIUS_W-1:0] radius_q;
	hvd_pkg::mq_view_t            q_view;
	logic                         q_pop;

	// Hold the radius; rewrite it only while no word is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Front: degree-to-turn conversion and quadrant fold, then a short queue.
	// It keeps taking words while the back end is stalled until that queue fills.
	hvd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.lat_a  (lat_a),
		.lon_a  (lon_a),
		.lat_b  (lat_b),
		.lon_b  (lon_b),
		.q_pop  (q_pop),
		.q_view (q_view)
	);

	// Back: sine/cosine, the haversine sum, roots, atan2 and radius scaling.
	// A two-entry result queue lets it keep draining while pop is low until full.
	hvd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radius     (radius_q),
		.q_view     (q_view),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.distance_m (distance_m)
	);

endmodule

### sim/haversine_distance_top_tb.sv
// Self-checking testbench for haversine_distance_top: drives point pairs through the
// queue-style ports and checks each distance against its own fixed-point predictor.
// Depends on hvd_pkg and the haversine_distance_top RTL only.
module haversine_distance_top_tb;

	// Angle constants in units of 2^-20 degree
	localparam longint DEG90  = 94371840;
	localparam longint DEG180 = 188743680;
	localparam int     GAP_MAX   = 18;
	localparam int     DRAIN_PAD = 2 * hvd_pkg::CORDIC_ITERATIONS + 60;
	localparam int     IDLE_LIMIT = 4000;
	localparam int     PHASE_ITEMS = 320;

	// Scoreboard: predicts the distance of each accepted word and checks results in order
	class dist_board;
		localparam longint GAIN_Q30 = 652032875;
		localparam longint ONE_Q30  = 64'sd1 << 30;
		localparam longint HALF_Q30 = 64'sd1 << 29;
		localparam longint ONE_Q60  = 64'sd1 << 60;
		localparam logic [63:0] PI_Q32 = 64'd13493037705;

		// atan(2^-i), one turn = 2^32
		longint atan_tab[24] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
			'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
			'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
			'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
			'h0000028C, 'h00000146, 'h000000A3, 'h00000051
		};

		logic [hvd_pkg::RADIUS_W-1:0] radius;
		logic [hvd_pkg::DIST_W-1:0]   pending[$];
		int                           errors;
		int                           checked;

		function new();
			radius = hvd_pkg::RADIUS_RESET;
			errors = 0;
			checked = 0;
		endfunction

		// round(v * 2^k / 360) half away from zero, wrapped to one turn
		function logic [31:0] deg_turn(longint v, int k);
			logic [63:0] m;
			m = (v < 0) ? -v : v;
			m = ((m << k) + 180) / 360;
			if (v < 0)
				m = -m;
			return m[31:0];
		endfunction

		function void spin(logic [31:0] turn, output longint c, output longint s);
			longint x, y, z, dx, dy;
			bit flip;
			z = $signed(turn);
			x = GAIN_Q30;
			y = 0;
			flip = 0;
			if (z > ONE_Q30) begin
				z -= 2 * ONE_Q30;
				flip = 1;
			end else if (z < -ONE_Q30) begin
				z += 2 * ONE_Q30;
				flip = 1;
			end
			for (int i = 0; i < hvd_pkg::CORDIC_ITERATIONS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint half_angle(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			x = x * 65536;
			y = y * 65536;
			for (int i = 0; i < hvd_pkg::CORDIC_ITERATIONS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			if (z < 0) z = 0;
			if (z > ONE_Q30) z = ONE_Q30;
			return z;
		endfunction

		function logic [63:0] floor_root(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// Note an accepted word: push its expected distance
		function void note(longint la, longint oa, longint lb, longint ob);
			longint ca, sa, cb, sb, ch, slat, clon, slon, cab, p, a60, ang;
			logic [63:0] ry, rx, cq, dist_exp;
			spin(deg_turn(la, hvd_pkg::LAT_SHIFT), ca, sa);
			spin(deg_turn(lb, hvd_pkg::LAT_SHIFT), cb, sb);
			spin(deg_turn(lb - la, hvd_pkg::HALF_SHIFT), ch, slat);
			spin(deg_turn(ob - oa, hvd_pkg::HALF_SHIFT), clon, slon);
			cab = (ca * cb + HALF_Q30) >>> 30;
			p = (cab * slon + HALF_Q30) >>> 30;
			a60 = slat * slat + p * slon;
			if (a60 < 0) a60 = 0;
			if (a60 > ONE_Q60) a60 = ONE_Q60;
			ry = floor_root(a60);
			rx = floor_root(ONE_Q60 - a60);
			ang = half_angle(rx, ry);
			cq = (64'(ang) * PI_Q32 + (64'd1 << 29)) >> 30;
			dist_exp = (64'(radius) * cq + (64'd1 << 31)) >> 32;
			pending.push_back(dist_exp[hvd_pkg::DIST_W-1:0]);
		endfunction

		task report(string what, logic [hvd_pkg::DIST_W-1:0] want,
			logic [hvd_pkg::DIST_W-1:0] got);
			$display("mismatch: %s expected %0d got %0d", what, want, got);
			errors++;
		endtask

		// Check a popped result against the oldest expectation
		task check(logic [hvd_pkg::DIST_W-1:0] got);
			checked++;
			if (pending.size() == 0)
				report("unexpected word,", '0, got);
			else begin
				logic [hvd_pkg::DIST_W-1:0] want;
				want = pending.pop_front();
				if (want !== got)
					report("distance_m", want, got);
			end
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic full, empty;
	logic signed [hvd_pkg::LAT_W-1:0] lat_a = 0, lat_b = 0;
	logic signed [hvd_pkg::LON_W-1:0] lon_a = 0, lon_b = 0;
	logic [hvd_pkg::DIST_W-1:0] distance_m;
	logic cfg_we = 0;
	logic [hvd_pkg::RADIUS_W-1:0] cfg_wdata = 0;

	dist_board board = new();
	int words_sent = 0;
	int idle_cycles = 0;
	int radius_settings = 1;

	haversine_distance_top dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.empty(empty), .pop(pop), .distance_m(distance_m),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if no word moves on either side for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: stall a random number of cycles, then hold pop until a word moves
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1;
			do @(posedge clk); while (empty);
			board.check(distance_m);
		end
	end

	// Send one word: idle for a random gap, then hold push until it is taken
	task automatic send(longint la, longint oa, longint lb, longint ob, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		lat_a <= la[hvd_pkg::LAT_W-1:0];
		lon_a <= oa[hvd_pkg::LON_W-1:0];
		lat_b <= lb[hvd_pkg::LAT_W-1:0];
		lon_b <= ob[hvd_pkg::LON_W-1:0];
		do @(posedge clk); while (full);
		board.note($signed(la[hvd_pkg::LAT_W-1:0]), $signed(oa[hvd_pkg::LON_W-1:0]),
			$signed(lb[hvd_pkg::LAT_W-1:0]), $signed(ob[hvd_pkg::LON_W-1:0]));
		words_sent++;
	endtask

	// Hold the sender until every expected word has come back, then let the pipe settle
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radius(logic [hvd_pkg::RADIUS_W-1:0] r);
		drain();
		cfg_we <= 1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 0;
		board.radius = r;
		radius_settings++;
	endtask

	function automatic longint pick_lat();
		return longint'($urandom_range(0, 2 * DEG90)) - DEG90;
	endfunction

	function automatic longint pick_lon();
		return longint'($urandom_range(0, 2 * DEG180)) - DEG180;
	endfunction

	// Mostly in-range pairs, some close together, some near antipodal, some raw noise
	task automatic random_phase(int n);
		longint la, oa, lb, ob;
		int kind;
		bit burst;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			la = pick_lat();
			oa = pick_lon();
			case (kind)
				0, 1: begin
					lb = la + $signed($urandom_range(0, 2000)) - 1000;
					ob = oa + $signed($urandom_range(0, 2000)) - 1000;
				end
				2: begin
					lb = -la + $signed($urandom_range(0, 64)) - 32;
					ob = oa + DEG180 - $urandom_range(0, 64);
				end
				3: begin
					la = $signed($urandom);
					oa = $signed($urandom);
					lb = $signed($urandom);
					ob = $signed($urandom);
				end
				default: begin
					lb = pick_lat();
					ob = pick_lon();
				end
			endcase
			burst = ($urandom_range(0, 199) < 20);
			send(la, oa, lb, ob, burst);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: same point, poles, antipodes, date-line wrap, field extremes
		send(0, 0, 0, 0, 0);
		send(DEG90, 0, -DEG90, 0, 0);
		send(0, 0, 0, DEG180, 1);
		send(0, -DEG180, 0, DEG180, 1);
		send(DEG90, DEG180, DEG90, -DEG180, 0);
		send(-DEG90, -DEG180, DEG90, DEG180, 0);
		send(0, 0, 1, 1, 0);
		send(0, 0, 0, 1, 0);
		send(DEG90, 0, DEG90 - 1, 0, 0);
		send(12345678, -98765432, 12345678, -98765432, 0);
		send(0, 0, 0, DEG180 - 1, 0);
		send(DEG90 / 2, 0, -DEG90 / 2, DEG180, 0);
		send(134217727, 268435455, -134217728, -268435456, 0);
		send(-134217728, -268435456, 134217727, 268435455, 1);
		send(DEG90 + 1000, 0, 0, 0, 0);
		send(-1, -1, 1, 1, 0);
		send(0, 0, DEG90, DEG180 / 2, 0);

		random_phase(PHASE_ITEMS);

		// Radius extremes, zero, a random value, then back to the reset value
		write_radius(1);
		random_phase(PHASE_ITEMS / 2);
		write_radius({hvd_pkg::RADIUS_W{1'b1}});
		send(0, 0, 0, DEG180, 0);
		random_phase(PHASE_ITEMS);
		write_radius(0);
		random_phase(PHASE_ITEMS / 4);
		write_radius(hvd_pkg::RADIUS_W'($urandom_range(1, (1 << hvd_pkg::RADIUS_W) - 1)));
		random_phase(PHASE_ITEMS);
		write_radius(hvd_pkg::RADIUS_RESET);
		random_phase(PHASE_ITEMS);

		push <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);

		if (board.pending.size() != 0)
			board.report("words never returned, count", '0,
				hvd_pkg::DIST_W'(board.pending.size()));
		$display("covered %0d point pairs, %0d results checked, %0d radius settings",
			words_sent, board.checked, radius_settings);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
